// ===== rtl/slic_rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// slic_rhc_pkg: shared types and constants of the ring and hook controller
// Transaction payloads, configuration layout, line state and opcodes.
// ----------------------------------------------------------------------------
`default_nettype none

package slic_rhc_pkg;

	// Configuration port geometry.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 12;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_RING_HALF_PERIOD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RING_ON_STEPS    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RING_PAUSE_STEPS = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_POWER_UP         = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_ONHOOK_RETRY     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_OFFHOOK_POLL     = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [7:0]  RST_RING_HALF_PERIOD = 8'd25;
	localparam logic [6:0]  RST_RING_ON_STEPS    = 7'd30;
	localparam logic [6:0]  RST_RING_PAUSE_STEPS = 7'd50;
	localparam logic [11:0] RST_POWER_UP         = 12'd100;
	localparam logic [11:0] RST_ONHOOK_RETRY     = 12'd1000;
	localparam logic [11:0] RST_OFFHOOK_POLL     = 12'd50;

	// Input opcodes.
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_RING   = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;

	// Ring step value that a cancel leaves behind.
	localparam logic [7:0] RING_STEP_CANCEL = 8'hFF;

	// Line mode, also reported as line status.
	typedef enum logic [1:0] {
		MODE_ONHOOK  = 2'd0,
		MODE_OFFHOOK = 2'd1,
		MODE_RINGING = 2'd2
	} line_mode_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] ring_count;
		logic       hook_off;
	} in_item_t;

	typedef struct packed {
		logic       power_on;
		logic       ring_mode;
		logic       ring_forward;
		logic [1:0] line_status;
		logic       ring_accepted;
	} result_t;

	typedef struct packed {
		logic [7:0]  ring_half_period_ms;
		logic [6:0]  ring_on_steps;
		logic [6:0]  ring_pause_steps;
		logic [11:0] power_up_ms;
		logic [11:0] onhook_retry_ms;
		logic [11:0] offhook_poll_ms;
	} cfg_t;

	typedef struct packed {
		line_mode_t  line_mode;
		logic [11:0] wait_left;
		logic        onhook_phase;
		logic [7:0]  ring_step;
		logic [7:0]  bursts_left;
		logic        power;
		logic        ring_mode;
		logic        polarity;
	} line_state_t;

endpackage

`default_nettype wire

// ===== rtl/slic_rhc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// slic_rhc_cfg_regs: configuration register file
// Holds the six timing registers, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module slic_rhc_cfg_regs (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 wr_en,
	input  wire [slic_rhc_pkg::CFG_INDEX_W-1:0] index,
	input  wire [slic_rhc_pkg::CFG_DATA_W-1:0]  data,
	output slic_rhc_pkg::cfg_t                  cfg
);

	slic_rhc_pkg::cfg_t cfg_q;

	// Each write lands in the register selected by the index; others are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ring_half_period_ms <= slic_rhc_pkg::RST_RING_HALF_PERIOD;
			cfg_q.ring_on_steps       <= slic_rhc_pkg::RST_RING_ON_STEPS;
			cfg_q.ring_pause_steps    <= slic_rhc_pkg::RST_RING_PAUSE_STEPS;
			cfg_q.power_up_ms         <= slic_rhc_pkg::RST_POWER_UP;
			cfg_q.onhook_retry_ms     <= slic_rhc_pkg::RST_ONHOOK_RETRY;
			cfg_q.offhook_poll_ms     <= slic_rhc_pkg::RST_OFFHOOK_POLL;
		end else if (wr_en) begin
			unique case (index)
				slic_rhc_pkg::CFG_RING_HALF_PERIOD: cfg_q.ring_half_period_ms <= data[7:0];
				slic_rhc_pkg::CFG_RING_ON_STEPS:    cfg_q.ring_on_steps       <= data[6:0];
				slic_rhc_pkg::CFG_RING_PAUSE_STEPS: cfg_q.ring_pause_steps    <= data[6:0];
				slic_rhc_pkg::CFG_POWER_UP:         cfg_q.power_up_ms         <= data;
				slic_rhc_pkg::CFG_ONHOOK_RETRY:     cfg_q.onhook_retry_ms     <= data;
				slic_rhc_pkg::CFG_OFFHOOK_POLL:     cfg_q.offhook_poll_ms     <= data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/slic_rhc_step.sv =====
// ----------------------------------------------------------------------------
// slic_rhc_step: line state update for one transaction
// Combinational next state and result for a tick, ring request or cancel.
// ----------------------------------------------------------------------------
`default_nettype none

module slic_rhc_step (
	input  wire slic_rhc_pkg::line_state_t state_cur,
	input  wire slic_rhc_pkg::in_item_t    item,
	input  wire slic_rhc_pkg::cfg_t        cfg,
	output slic_rhc_pkg::line_state_t      state_next,
	output slic_rhc_pkg::result_t          result
);

	slic_rhc_pkg::line_state_t s;
	logic        accepted;
	logic        act;
	logic [11:0] wait_dec;
	logic [7:0]  n_on;
	logic [7:0]  burst_len;
	logic [7:0]  step_inc;
	logic        burst_done;
	logic [7:0]  bursts_after;

	// Ring cadence arithmetic, all on 8-bit values.
	assign n_on         = {1'b0, cfg.ring_on_steps};
	assign burst_len    = n_on + {1'b0, cfg.ring_pause_steps};
	assign step_inc     = state_cur.ring_step + 8'd1;
	assign burst_done   = (step_inc >= burst_len);
	assign bursts_after = (burst_done && (state_cur.bursts_left != 8'd0)) ?
		state_cur.bursts_left - 8'd1 : state_cur.bursts_left;

	// The pending wait runs out on this tick when it is zero or reaches zero.
	assign wait_dec = state_cur.wait_left - 12'd1;
	assign act      = (state_cur.wait_left == 12'd0) || (wait_dec == 12'd0);

	always_comb begin
		s        = state_cur;
		accepted = 1'b0;
		case (item.opcode)
			slic_rhc_pkg::OP_TICK: begin
				if (!act) begin
					s.wait_left = wait_dec;
				end else begin
					case (state_cur.line_mode)
						slic_rhc_pkg::MODE_OFFHOOK: begin
							if (!item.hook_off) begin
								s.line_mode    = slic_rhc_pkg::MODE_ONHOOK;
								s.power        = 1'b1;
								s.wait_left    = cfg.power_up_ms;
								s.onhook_phase = 1'b1;
							end else begin
								s.wait_left = cfg.offhook_poll_ms;
							end
						end
						slic_rhc_pkg::MODE_RINGING: begin
							if (item.hook_off) begin
								// Handset lifted during ringing: answer the call.
								s.ring_mode    = 1'b0;
								s.polarity     = 1'b0;
								s.line_mode    = slic_rhc_pkg::MODE_OFFHOOK;
								s.onhook_phase = 1'b0;
								s.wait_left    = cfg.offhook_poll_ms;
							end else begin
								// One ring step: start, toggle or stop the burst.
								if (state_cur.ring_step == 8'd0) begin
									s.ring_mode = 1'b1;
								end else if (state_cur.ring_step < n_on) begin
									s.polarity = ~state_cur.ring_step[0];
								end else if (state_cur.ring_step == n_on) begin
									s.ring_mode = 1'b0;
									s.polarity  = 1'b0;
								end
								s.ring_step   = burst_done ? 8'd0 : step_inc;
								s.bursts_left = bursts_after;
								if (bursts_after == 8'd0) begin
									s.ring_mode    = 1'b0;
									s.polarity     = 1'b0;
									s.line_mode    = slic_rhc_pkg::MODE_ONHOOK;
									s.power        = 1'b1;
									s.wait_left    = cfg.power_up_ms;
									s.onhook_phase = 1'b1;
								end else begin
									s.wait_left = {4'd0, cfg.ring_half_period_ms};
								end
							end
						end
						default: begin
							// On hook: power up, then sample the hook after the wait.
							s.line_mode = slic_rhc_pkg::MODE_ONHOOK;
							if (!state_cur.onhook_phase) begin
								s.power        = 1'b1;
								s.wait_left    = cfg.power_up_ms;
								s.onhook_phase = 1'b1;
							end else if (!item.hook_off) begin
								s.power        = 1'b0;
								s.wait_left    = cfg.onhook_retry_ms;
								s.onhook_phase = 1'b0;
							end else begin
								s.line_mode    = slic_rhc_pkg::MODE_OFFHOOK;
								s.onhook_phase = 1'b0;
								s.wait_left    = cfg.offhook_poll_ms;
							end
						end
					endcase
				end
			end
			slic_rhc_pkg::OP_RING: begin
				// A ring request is taken only on hook and drops any pending wait.
				if (state_cur.line_mode == slic_rhc_pkg::MODE_ONHOOK) begin
					s.power        = 1'b1;
					s.line_mode    = slic_rhc_pkg::MODE_RINGING;
					s.ring_step    = 8'd0;
					s.bursts_left  = (item.ring_count == 8'd0) ? 8'd1 : item.ring_count;
					s.wait_left    = 12'd0;
					s.onhook_phase = 1'b0;
					accepted       = 1'b1;
				end
			end
			slic_rhc_pkg::OP_CANCEL: begin
				// Ringing ends at its next step.
				s.bursts_left = 8'd0;
				s.ring_step   = slic_rhc_pkg::RING_STEP_CANCEL;
			end
			default: begin
			end
		endcase
	end

	assign state_next            = s;
	assign result.power_on       = s.power;
	assign result.ring_mode      = s.ring_mode;
	assign result.ring_forward   = s.polarity;
	assign result.line_status    = s.line_mode;
	assign result.ring_accepted  = accepted;

endmodule

`default_nettype wire

// ===== rtl/slic_ring_hook_controller_core.sv =====
// ----------------------------------------------------------------------------
// slic_ring_hook_controller_core: ring and hook controller for a line chip
// Runs the timed on-hook, off-hook and ringing sequence one transaction at a
// time and reports the line chip drive after every transaction.
// ----------------------------------------------------------------------------
//  Channel   Signals                            Direction  Moves
//  in        in_valid, in_stall, in_data        input      tick / ring / cancel
//  out       out_valid, out_stall, out_data     output     line drive and status
//  cfg       cfg_wr_en, cfg_index, cfg_data     input      timing registers
//
//  A transaction is registered at the input, processed combinationally and its
//  result registered at the output; one per cycle while the output does not stall.
//  The line state register updates when the input stage moves to the output.
//  A stalled output holds its result; the input stage then stalls in turn.
//  Reset returns to on hook, powered down, with an action due on the next tick.
// ----------------------------------------------------------------------------
`default_nettype none

module slic_ring_hook_controller_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire slic_rhc_pkg::in_item_t         in_data,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output slic_rhc_pkg::result_t               out_data,
	input  wire                                 cfg_wr_en,
	input  wire [slic_rhc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire [slic_rhc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	slic_rhc_pkg::cfg_t        cfg;
	slic_rhc_pkg::in_item_t    item_s1;
	logic                      valid_s1;
	slic_rhc_pkg::line_state_t state_q;
	slic_rhc_pkg::line_state_t state_next;
	slic_rhc_pkg::result_t     result;
	slic_rhc_pkg::result_t     out_q;
	logic                      out_valid_q;
	logic                      advance;
	logic                      in_take;

	slic_rhc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	slic_rhc_step u_step (
		.state_cur  (state_q),
		.item       (item_s1),
		.cfg        (cfg),
		.state_next (state_next),
		.result     (result)
	);

	// Handshake: the input stage moves on when the output register is free.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_data;
		end
	end

	// Line state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.line_mode    <= slic_rhc_pkg::MODE_ONHOOK;
			state_q.wait_left    <= 12'd0;
			state_q.onhook_phase <= 1'b0;
			state_q.ring_step    <= 8'd0;
			state_q.bursts_left  <= 8'd0;
			state_q.power        <= 1'b0;
			state_q.ring_mode    <= 1'b0;
			state_q.polarity     <= 1'b0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A processed transaction always shows up at the output on the next cycle.
	a_advance_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed transaction did not reach the output register");

	// The input side only stalls behind a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a held result");

	// An accepted ring request always leaves the line ringing.
	a_ring_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.ring_accepted) |->
		(out_q.line_status == slic_rhc_pkg::MODE_RINGING))
		else $error("accepted ring request without ringing status");

	// Ring mode is driven only on a powered, ringing line.
	a_ring_mode_power: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.ring_mode |->
		(state_q.power && (state_q.line_mode == slic_rhc_pkg::MODE_RINGING)))
		else $error("ring mode active outside powered ringing");

endmodule

`default_nettype wire
